// ===== design/dvm_pkg.sv =====
// Shared types and constants of the decaying voice mixer.
`default_nettype none

package dvm_pkg;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_START = 2'd1,
    REQ_STOP  = 2'd2,
    REQ_WRITE = 2'd3
  } req_e;

  typedef struct packed {
    logic [15:0] amp;
    logic [15:0] astep;
    logic [23:0] inc;
    logic [23:0] istep;
    logic [31:0] pos;
    logic        loop;
    logic        clip;
    logic [15:0] base;
    logic [16:0] len;
    logic [23:0] cstep;
  } voice_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_START, OP_RD_SLOT, OP_STOP_WR, OP_MODA, OP_MODB, OP_MODR,
    OP_RD, OP_UPD, OP_AG, OP_AGSV, OP_SPH, OP_SIDX, OP_SQ, OP_SF, OP_SXX, OP_SX2,
    OP_ST1, OP_SXT, OP_ST2, OP_SXS, OP_SVAL, OP_CVAL, OP_MIX, OP_ACC, OP_WB,
    OP_REM, OP_CPY, OP_FIN
  } dp_op_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISP, ST_START, ST_STOP_RD, ST_STOP_WR, ST_MODA, ST_MODB, ST_MODR,
    ST_RD, ST_UPD, ST_AG, ST_AGSV, ST_SPH, ST_SIDX, ST_SQ, ST_SF, ST_SXX, ST_SX2,
    ST_ST1, ST_SXT, ST_ST2, ST_SXS, ST_SVAL, ST_CVAL, ST_MIX, ST_ACC, ST_WB,
    ST_REM, ST_CPY, ST_FIN
  } ctl_state_e;

  typedef struct packed {
    req_e req;
    logic cnt_zero;
    logic slot_ok;
    logic is_clip;
    logic done;
    logic looping;
    logic more;
    logic idx_lt;
    logic out_free;
  } dvm_status_t;

  localparam logic [15:0] GAIN_RESET   = 16'd13107;
  localparam logic [16:0] LEN_MAX      = 17'd65536;
  localparam logic [14:0] SINE_QUARTER = 15'd16384;
  localparam logic [14:0] SINE_A       = 15'd10583;
  localparam logic [31:0] SINE_B       = 32'd1306;
  localparam logic [14:0] SINE_C       = 15'd25736;

endpackage

`default_nettype wire

// ===== design/dvm_ctrl.sv =====
// Sequencing state machine of the decaying voice mixer.
`default_nettype none

module dvm_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  dvm_pkg::dvm_status_t  status_i,
  output dvm_pkg::dp_op_e       op_o
);
  import dvm_pkg::*;

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    op_o       = OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_o    = OP_LOAD;
          state_d = ST_DISP;
        end
      end
      ST_DISP: begin
        case (status_i.req)
          REQ_TICK:  state_d = status_i.cnt_zero ? ST_FIN : ST_RD;
          REQ_START: state_d = ST_START;
          REQ_STOP:  state_d = status_i.slot_ok ? ST_STOP_RD : ST_FIN;
          REQ_WRITE: state_d = ST_MODA;
          default:   state_d = ST_FIN;
        endcase
      end
      ST_START: begin
        op_o = OP_START;
        state_d = ST_FIN;
      end
      ST_STOP_RD: begin
        op_o = OP_RD_SLOT;
        state_d = ST_STOP_WR;
      end
      ST_STOP_WR: begin
        op_o = OP_STOP_WR;
        state_d = ST_FIN;
      end
      ST_MODA: begin
        op_o = OP_MODA;
        state_d = ST_MODB;
      end
      ST_MODB: begin
        op_o = OP_MODB;
        state_d = ST_MODR;
      end
      ST_MODR: begin
        op_o = OP_MODR;
        state_d = (status_i.req == REQ_WRITE) ? ST_FIN : ST_CVAL;
      end
      ST_RD: begin
        op_o = OP_RD;
        state_d = ST_UPD;
      end
      ST_UPD: begin
        op_o = OP_UPD;
        state_d = ST_AG;
      end
      ST_AG: begin
        op_o = OP_AG;
        state_d = ST_AGSV;
      end
      ST_AGSV: begin
        op_o = OP_AGSV;
        state_d = status_i.is_clip ? ST_MODA : ST_SPH;
      end
      ST_SPH: begin
        op_o = OP_SPH;
        state_d = ST_SIDX;
      end
      ST_SIDX: begin
        op_o = OP_SIDX;
        state_d = ST_SQ;
      end
      ST_SQ: begin
        op_o = OP_SQ;
        state_d = ST_SF;
      end
      ST_SF: begin
        op_o = OP_SF;
        state_d = ST_SXX;
      end
      ST_SXX: begin
        op_o = OP_SXX;
        state_d = ST_SX2;
      end
      ST_SX2: begin
        op_o = OP_SX2;
        state_d = ST_ST1;
      end
      ST_ST1: begin
        op_o = OP_ST1;
        state_d = ST_SXT;
      end
      ST_SXT: begin
        op_o = OP_SXT;
        state_d = ST_ST2;
      end
      ST_ST2: begin
        op_o = OP_ST2;
        state_d = ST_SXS;
      end
      ST_SXS: begin
        op_o = OP_SXS;
        state_d = ST_SVAL;
      end
      ST_SVAL: begin
        op_o = OP_SVAL;
        state_d = ST_MIX;
      end
      ST_CVAL: begin
        op_o = OP_CVAL;
        state_d = ST_MIX;
      end
      ST_MIX: begin
        op_o = OP_MIX;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        op_o = OP_ACC;
        state_d = (status_i.done && !status_i.looping) ? ST_REM : ST_WB;
      end
      ST_WB: begin
        op_o = OP_WB;
        state_d = status_i.more ? ST_RD : ST_FIN;
      end
      ST_REM: begin
        op_o = OP_REM;
        state_d = ST_CPY;
      end
      ST_CPY: begin
        op_o = OP_CPY;
        state_d = status_i.idx_lt ? ST_RD : ST_FIN;
      end
      ST_FIN: begin
        if (status_i.out_free) begin
          op_o    = OP_FIN;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/dvm_datapath.sv =====
// Voice table, clip store, shared multiplier and output register of the mixer.
`default_nettype none

module dvm_datapath #(
  parameter int VOICES       = 10,
  parameter int CLIP_WORDS   = 65536,
  parameter int SINE_ENTRIES = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dvm_pkg::dp_op_e       op_i,
  output dvm_pkg::dvm_status_t  status_o,
  input  logic                  mix_gain_we_i,
  input  logic [15:0]           mix_gain_i,
  input  logic [1:0]            req_type_i,
  input  logic [15:0]           amplitude_i,
  input  logic [23:0]           frequency_i,
  input  logic [15:0]           amp_step_i,
  input  logic [23:0]           freq_step_i,
  input  logic                  looping_i,
  input  logic                  use_clip_i,
  input  logic [23:0]           clip_step_i,
  input  logic [16:0]           clip_length_i,
  input  logic [3:0]            voice_slot_i,
  input  logic [15:0]           sample_addr_i,
  input  logic signed [15:0]    sample_value_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic signed [15:0]    mixed_sample_o,
  output logic                  accepted_o,
  output logic [3:0]            assigned_slot_o,
  output logic [3:0]            active_voices_o
);
  import dvm_pkg::*;

  localparam int SW   = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CW   = $clog2(VOICES + 1);
  localparam int AW   = $clog2(CLIP_WORDS);
  localparam int IW   = $clog2(SINE_ENTRIES);
  localparam int ACCW = 49 + $clog2(VOICES);
  localparam logic [32:0] RECIP_C = 33'((64'd1 << 32) / CLIP_WORDS);
  localparam logic [32:0] RECIP_S = 33'((64'd1 << 32) / SINE_ENTRIES);
  localparam logic [31:0] CLIP_W32 = 32'(CLIP_WORDS);
  localparam logic [31:0] SINE_W32 = 32'(SINE_ENTRIES);
  localparam logic [21:0] CLIP_W22 = 22'(CLIP_WORDS);
  localparam logic signed [ACCW:0] RND_HALF = {{(ACCW-31){1'b0}}, 1'b1, 31'b0};
  localparam logic signed [ACCW-32:0] SAT_MAX = (ACCW-31)'(32767);
  localparam logic signed [ACCW-32:0] SAT_MIN = (ACCW-31)'(-32768);

  voice_t vmem [VOICES];
  voice_t rd_q, cur_q, upd_rec, new_rec, wr_data;
  logic signed [15:0] smem [CLIP_WORDS];
  logic signed [15:0] srd_q;

  logic [CW-1:0] cnt_q, idx_q, cnt_m1;
  logic [15:0]   gain_q;
  logic          out_valid_q;

  req_e          req_q;
  logic [15:0]   amp_in_q, astep_in_q, addr_in_q;
  logic [23:0]   freq_in_q, fstep_in_q, cstep_in_q;
  logic          loop_in_q, clip_in_q;
  logic [16:0]   len_in_q;
  logic [3:0]    slot_in_q;
  logic signed [15:0] sval_in_q;

  logic signed [50:0] prod_q, prod_d;
  logic signed [17:0] mul_a;
  logic [31:0]   mul_b;
  logic [31:0]   ag_q;
  logic [16:0]   n_q;
  logic [23:0]   ph_q;
  logic [IW-1:0] sidx_q;
  logic [15:0]   q_q;
  logic [14:0]   x_q, x2_q, t_q;
  logic [1:0]    quad_q;
  logic signed [15:0] val_q;
  logic signed [ACCW-1:0] acc_q;
  logic          done_q;
  logic          res_ok_q;
  logic [3:0]    res_slot_q;
  logic signed [15:0] out_mix_q;
  logic          out_ok_q;
  logic [3:0]    out_slot_q, out_cnt_q;

  logic          full;
  logic [15:0]   namp;
  logic [23:0]   ninc;
  logic [32:0]   np;
  logic          cend, dn;
  logic [31:0]   npos;
  logic [16:0]   nsum;
  logic [31:0]   rem;
  logic [15:0]   f_val;
  logic [14:0]   x_new;
  logic [15:0]   s_raw, s_cl;
  logic signed [15:0] s_val;
  logic [21:0]   r_mod, r_fix;
  logic [AW-1:0] saddr;
  logic signed [ACCW:0] rnd;
  logic signed [ACCW-32:0] sh;
  logic signed [15:0] sat;
  logic          wr_en, rd_en;
  logic [SW-1:0] wr_addr, rd_addr;

  assign full   = cnt_q >= CW'(VOICES);
  assign cnt_m1 = cnt_q - CW'(1);

  always_comb begin
    namp = (rd_q.amp > rd_q.astep) ? rd_q.amp - rd_q.astep : 16'd0;
    ninc = (rd_q.inc > rd_q.istep) ? rd_q.inc - rd_q.istep : 24'd0;
    np   = {1'b0, rd_q.pos} + {9'b0, rd_q.cstep};
    cend = np >= {rd_q.len, 16'b0};
    dn   = (namp == 16'd0) || (rd_q.clip && cend);
    if (rd_q.clip) begin
      npos = cend ? 32'd0 : np[31:0];
    end else begin
      npos = {8'b0, rd_q.pos[23:0] + ninc};
    end
    if (dn && rd_q.loop) begin
      npos = 32'd0;
    end
    upd_rec     = rd_q;
    upd_rec.amp = namp;
    upd_rec.inc = ninc;
    upd_rec.pos = npos;
    nsum = {1'b0, rd_q.base} + {1'b0, rd_q.pos[31:16]};
  end

  always_comb begin
    new_rec.amp   = amp_in_q;
    new_rec.astep = astep_in_q;
    new_rec.inc   = freq_in_q;
    new_rec.istep = fstep_in_q;
    new_rec.pos   = 32'd0;
    new_rec.loop  = loop_in_q;
    new_rec.clip  = clip_in_q;
    new_rec.base  = addr_in_q;
    new_rec.len   = (len_in_q > LEN_MAX) ? LEN_MAX : len_in_q;
    new_rec.cstep = cstep_in_q;
  end

  always_comb begin
    rem   = (32'(sidx_q) << 16) - prod_q[31:0];
    f_val = (rem >= SINE_W32) ? q_q + 16'd1 : q_q;
    x_new = f_val[14] ? SINE_QUARTER - {1'b0, f_val[13:0]} : {1'b0, f_val[13:0]};
    s_raw = {prod_q[28:14], 1'b0};
    s_cl  = s_raw[15] ? 16'd32767 : s_raw;
    s_val = quad_q[1] ? -$signed(s_cl) : $signed(s_cl);
    r_mod = {5'b0, n_q} - prod_q[21:0];
    r_fix = (r_mod >= CLIP_W22) ? r_mod - CLIP_W22 : r_mod;
    saddr = r_fix[AW-1:0];
    rnd   = {acc_q[ACCW-1], acc_q} + RND_HALF;
    sh    = rnd[ACCW:32];
    if (sh > SAT_MAX) begin
      sat = 16'sh7fff;
    end else if (sh < SAT_MIN) begin
      sat = -16'sh8000;
    end else begin
      sat = sh[15:0];
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_i)
      OP_AG: begin
        mul_a = {2'b0, cur_q.amp};
        mul_b = {16'b0, gain_q};
      end
      OP_MODA: begin
        mul_a = {1'b0, n_q};
        mul_b = RECIP_C[31:0];
      end
      OP_MODB: begin
        mul_a = {1'b0, prod_q[48:32]};
        mul_b = CLIP_W32;
      end
      OP_SPH: begin
        mul_a = 18'(SINE_ENTRIES);
        mul_b = {8'b0, ph_q};
      end
      OP_SIDX: begin
        mul_a = 18'(prod_q[24 +: IW]);
        mul_b = RECIP_S[31:0];
      end
      OP_SQ: begin
        mul_a = {2'b0, prod_q[31:16]};
        mul_b = SINE_W32;
      end
      OP_SXX: begin
        mul_a = {3'b0, x_q};
        mul_b = {17'b0, x_q};
      end
      OP_SX2: begin
        mul_a = {3'b0, prod_q[28:14]};
        mul_b = SINE_B;
      end
      OP_SXT: begin
        mul_a = {3'b0, x2_q};
        mul_b = {17'b0, t_q};
      end
      OP_SXS: begin
        mul_a = {3'b0, x_q};
        mul_b = {17'b0, t_q};
      end
      OP_MIX: begin
        mul_a = {{2{val_q[15]}}, val_q};
        mul_b = ag_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = mul_a * $signed({1'b0, mul_b});
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_q[SW-1:0];
    wr_data = cur_q;
    rd_en   = 1'b0;
    rd_addr = idx_q[SW-1:0];
    case (op_i)
      OP_START: begin
        wr_en   = !full;
        wr_addr = cnt_q[SW-1:0];
        wr_data = new_rec;
      end
      OP_STOP_WR: begin
        wr_en       = 1'b1;
        wr_addr     = SW'(slot_in_q);
        wr_data     = rd_q;
        wr_data.amp = 16'd0;
      end
      OP_WB: wr_en = 1'b1;
      OP_CPY: begin
        wr_en   = 1'b1;
        wr_data = rd_q;
      end
      OP_RD: rd_en = 1'b1;
      OP_RD_SLOT: begin
        rd_en   = 1'b1;
        rd_addr = SW'(slot_in_q);
      end
      OP_REM: begin
        rd_en   = 1'b1;
        rd_addr = cnt_m1[SW-1:0];
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      vmem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= vmem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i == OP_MODR && req_q == REQ_WRITE) begin
      smem[saddr] <= sval_in_q;
    end
    if (op_i == OP_MODR && req_q != REQ_WRITE) begin
      srd_q <= smem[saddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      idx_q       <= '0;
      gain_q      <= GAIN_RESET;
      out_valid_q <= 1'b0;
      req_q       <= REQ_TICK;
    end else begin
      if (mix_gain_we_i) begin
        gain_q <= mix_gain_i;
      end
      if (op_i == OP_LOAD) begin
        req_q <= req_e'(req_type_i);
        idx_q <= '0;
      end
      if (op_i == OP_WB) begin
        idx_q <= idx_q + CW'(1);
      end
      if (op_i == OP_START && !full) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (op_i == OP_REM) begin
        cnt_q <= cnt_m1;
      end
      if (op_i == OP_FIN) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (op_i)
      OP_LOAD: begin
        amp_in_q   <= amplitude_i;
        astep_in_q <= amp_step_i;
        freq_in_q  <= frequency_i;
        fstep_in_q <= freq_step_i;
        loop_in_q  <= looping_i;
        clip_in_q  <= use_clip_i;
        cstep_in_q <= clip_step_i;
        len_in_q   <= clip_length_i;
        slot_in_q  <= voice_slot_i;
        addr_in_q  <= sample_addr_i;
        sval_in_q  <= sample_value_i;
        n_q        <= {1'b0, sample_addr_i};
        acc_q      <= '0;
        res_ok_q   <= 1'b1;
        res_slot_q <= 4'd0;
      end
      OP_START: begin
        if (full) begin
          res_ok_q <= 1'b0;
        end else begin
          res_slot_q <= 4'(cnt_q);
        end
      end
      OP_UPD: begin
        cur_q  <= upd_rec;
        done_q <= dn;
        n_q    <= nsum;
        ph_q   <= rd_q.pos[23:0];
      end
      OP_AGSV: ag_q <= prod_q[31:0];
      OP_SIDX: sidx_q <= prod_q[24 +: IW];
      OP_SQ:   q_q <= prod_q[31:16];
      OP_SF: begin
        x_q    <= x_new;
        quad_q <= f_val[15:14];
      end
      OP_SX2:  x2_q <= prod_q[28:14];
      OP_ST1:  t_q <= SINE_A - {4'b0, prod_q[24:14]};
      OP_ST2:  t_q <= SINE_C - {1'b0, prod_q[27:14]};
      OP_SVAL: val_q <= s_val;
      OP_CVAL: val_q <= srd_q;
      OP_ACC:  acc_q <= acc_q + ACCW'(prod_q);
      OP_FIN: begin
        out_mix_q  <= (req_q == REQ_TICK) ? sat : 16'sd0;
        out_ok_q   <= res_ok_q;
        out_slot_q <= res_slot_q;
        out_cnt_q  <= 4'(cnt_q);
      end
      default: done_q <= done_q;
    endcase
  end

  always_comb begin
    status_o.req      = req_q;
    status_o.cnt_zero = cnt_q == '0;
    status_o.slot_ok  = {4'b0, slot_in_q} < 8'(cnt_q);
    status_o.is_clip  = cur_q.clip;
    status_o.done     = done_q;
    status_o.looping  = cur_q.loop;
    status_o.more     = ({1'b0, idx_q} + (CW+1)'(1)) < {1'b0, cnt_q};
    status_o.idx_lt   = idx_q < cnt_q;
    status_o.out_free = !out_valid_q || out_ready_i;
  end

  assign out_valid_o     = out_valid_q;
  assign mixed_sample_o  = out_mix_q;
  assign accepted_o      = out_ok_q;
  assign assigned_slot_o = out_slot_q;
  assign active_voices_o = out_cnt_q;

endmodule

`default_nettype wire

// ===== design/decaying_voice_mixer.sv =====
// Top level of the decaying voice mixer: controller plus datapath.
// Usage: items enter on in_valid_i/in_ready_o; one result per item leaves on
// out_valid_o/out_ready_i. A transfer happens when valid and ready are both high.
// A tick item mixes all active voices; start, stop and write items edit the voice
// table or the clip store. The gain register is written with mix_gain_we_i.
// A start item fills the next free voice slot if one is left; a stop item reads the
// named slot and zeroes its amplitude if it is in use; a write item stores a sample.
// A tick reads, updates and mixes each voice in turn on the single shared 18 by 32
// bit multiplier; a voice that ends and does not loop is replaced by the last slot.
// One item is in work at a time; the next item is taken once the result is in
// the output register, so a waiting result does not block the next transfer.
// If the receiver stalls while a second result is ready, the block waits.
// Reset clears the voice count, the output valid and sets the gain to 0.2.
// Voice slots and the clip store hold no reset value and need no clearing pass.
`default_nettype none

module decaying_voice_mixer #(
  parameter int VOICES       = 10,
  parameter int CLIP_WORDS   = 65536,
  parameter int SINE_ENTRIES = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               mix_gain_we_i,
  input  logic [15:0]        mix_gain_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic [15:0]        amplitude_i,
  input  logic [23:0]        frequency_i,
  input  logic [15:0]        amp_step_i,
  input  logic [23:0]        freq_step_i,
  input  logic               looping_i,
  input  logic               use_clip_i,
  input  logic [23:0]        clip_step_i,
  input  logic [16:0]        clip_length_i,
  input  logic [3:0]         voice_slot_i,
  input  logic [15:0]        sample_addr_i,
  input  logic signed [15:0] sample_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] mixed_sample_o,
  output logic               accepted_o,
  output logic [3:0]         assigned_slot_o,
  output logic [3:0]         active_voices_o
);
  import dvm_pkg::*;

  dp_op_e      op;
  dvm_status_t status;

  dvm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .op_o       (op)
  );

  dvm_datapath #(
    .VOICES       (VOICES),
    .CLIP_WORDS   (CLIP_WORDS),
    .SINE_ENTRIES (SINE_ENTRIES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (op),
    .status_o        (status),
    .mix_gain_we_i   (mix_gain_we_i),
    .mix_gain_i      (mix_gain_i),
    .req_type_i      (req_type_i),
    .amplitude_i     (amplitude_i),
    .frequency_i     (frequency_i),
    .amp_step_i      (amp_step_i),
    .freq_step_i     (freq_step_i),
    .looping_i       (looping_i),
    .use_clip_i      (use_clip_i),
    .clip_step_i     (clip_step_i),
    .clip_length_i   (clip_length_i),
    .voice_slot_i    (voice_slot_i),
    .sample_addr_i   (sample_addr_i),
    .sample_value_i  (sample_value_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .mixed_sample_o  (mixed_sample_o),
    .accepted_o      (accepted_o),
    .assigned_slot_o (assigned_slot_o),
    .active_voices_o (active_voices_o)
  );

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second item taken while one is in work");

  a_refused_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !accepted_o) |-> (active_voices_o == 4'(VOICES)))
    else $error("start refused while a slot was free");

  a_refused_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !accepted_o) |-> (mixed_sample_o == 16'sd0))
    else $error("refused start carries a mixed sample");

  a_fin_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == OP_FIN) |-> status.out_free)
    else $error("result loaded over a waiting result");

endmodule

`default_nettype wire
